// ===== rtl/core/bsrch_pkg.sv =====
// ----------------------------------------------------------------------------
// bsrch_pkg
// Shared constants, configuration and queue entry types for the byte pattern
// search block.
// ----------------------------------------------------------------------------
package bsrch_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int BLOCK_MAX   = 65536;

   localparam int BYTE_W   = 8;
   localparam int POS_W    = 16;
   localparam int LEN_W    = $clog2(PATTERN_MAX + 1);
   localparam int WIN_IX_W = $clog2(PATTERN_MAX);
   localparam int COUNT_W  = $clog2(BLOCK_MAX + 2);
   localparam int PAT_W    = PATTERN_MAX * BYTE_W;
   localparam int HALF_W   = 64;

   localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};
   localparam logic [COUNT_W-1:0] BLOCK_LIM = COUNT_W'(BLOCK_MAX);

   // Register file
   localparam int CSR_IX_W   = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IX_W-1:0] CSR_PATTERN_LO = 3'd0;
   localparam logic [CSR_IX_W-1:0] CSR_PATTERN_HI = 3'd1;
   localparam logic [CSR_IX_W-1:0] CSR_LENGTH     = 3'd2;
   localparam logic [CSR_IX_W-1:0] CSR_SKIP       = 3'd3;
   localparam logic [CSR_IX_W-1:0] CSR_ANCHOR_EN  = 3'd4;
   localparam logic [CSR_IX_W-1:0] CSR_ANCHOR_OFF = 3'd5;

   // Queue between classifier and result stage
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Result packing: found, position, too long, padded to bytes
   localparam int RSP_BITS   = 1 + POS_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic [PAT_W-1:0]  pattern;      // byte 0 in the lowest bits
      logic [LEN_W-1:0]  length;
      logic [POS_W-1:0]  skip;
      logic              anchor_en;
      logic [POS_W-1:0]  anchor_off;
   } cfg_type;

   typedef struct packed {
      logic              hit;          // a match ends on this byte
      logic [POS_W-1:0]  start;
      logic              last;
      logic              too_long;
   } entry_type;

endpackage

// ===== rtl/core/byte_pattern_search.sv =====
// ----------------------------------------------------------------------------
// byte_pattern_search
// Streaming search of a byte block for a configured pattern of 1 to 16 bytes.
// ----------------------------------------------------------------------------
// Usage: the block is fed one byte per item on the req_ channel, with
// req_tlast high on the final byte of the block. Exactly one result item
// leaves on the rsp_ channel per block, carrying the found flag, the start
// index of the first match and the too-long flag. The user must write the
// registers via the csr_ port only while idle; the block does not enforce it.
//
// Throughput is one byte per cycle while req_tready stays high: each byte is
// classified combinationally in the front stage by a sixteen-way byte
// compare against the window of newest bytes. With an empty queue and a free
// output register, the last byte of a block passes the front stage register
// and a queue slot before the output register takes it and raises rsp_tvalid.
//
// Reset clears the byte count, the match state, the queue and the output
// register, and returns the registers to their defaults (pattern length 1,
// everything else zero). When the receiver holds rsp_tready low, the result
// waits in the output register while later bytes keep draining through the
// queue. Only when the final byte of the following block reaches the head of
// the queue does draining stop; once the queue and the front stage are full,
// req_tready drops until the waiting result is taken.
// ----------------------------------------------------------------------------
module byte_pattern_search (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input bytes
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bsrch_pkg::BYTE_W-1:0]          req_tdata,   // [7:0] data_byte
   input  logic                                  req_tlast,   // last_byte
   // Results
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] found, [16:1] match_position, [17] block_too_long, rest zero
   output logic [bsrch_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Register writes
   input  logic                                  csr_we,
   input  logic [bsrch_pkg::CSR_IX_W-1:0]        csr_index,
   input  logic [bsrch_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [bsrch_pkg::HALF_W-1:0]  pat_lo_ff, pat_hi_ff;
   logic [bsrch_pkg::LEN_W-1:0]   length_ff;
   logic [bsrch_pkg::POS_W-1:0]   skip_ff;
   logic                          anchor_en_ff;
   logic [bsrch_pkg::POS_W-1:0]   anchor_off_ff;

   bsrch_pkg::cfg_type            cfg;
   bsrch_pkg::entry_type          push_entry, pop_entry;
   logic                          push, queue_full, pop, pop_valid;

   // Register file; indexes outside the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff     <= '0;
         pat_hi_ff     <= '0;
         length_ff     <= bsrch_pkg::LEN_W'(1);
         skip_ff       <= '0;
         anchor_en_ff  <= 1'b0;
         anchor_off_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bsrch_pkg::CSR_PATTERN_LO: begin
               pat_lo_ff <= csr_wdata;
            end
            bsrch_pkg::CSR_PATTERN_HI: begin
               pat_hi_ff <= csr_wdata;
            end
            bsrch_pkg::CSR_LENGTH: begin
               length_ff <= csr_wdata[bsrch_pkg::LEN_W-1:0];
            end
            bsrch_pkg::CSR_SKIP: begin
               skip_ff <= csr_wdata[bsrch_pkg::POS_W-1:0];
            end
            bsrch_pkg::CSR_ANCHOR_EN: begin
               anchor_en_ff <= csr_wdata[0];
            end
            bsrch_pkg::CSR_ANCHOR_OFF: begin
               anchor_off_ff <= csr_wdata[bsrch_pkg::POS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The pattern is one vector with byte 0 in the lowest bits.
   assign cfg.pattern    = {pat_hi_ff, pat_lo_ff};
   assign cfg.length     = length_ff;
   assign cfg.skip       = skip_ff;
   assign cfg.anchor_en  = anchor_en_ff;
   assign cfg.anchor_off = anchor_off_ff;

   // Front: window, byte count and per-byte match classification.
   bsrch_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // Short queue so that a stalled receiver does not at once stop the byte stream.
   bsrch_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // Back: first-match tracking and the result register.
   bsrch_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_entry    (pop_entry),
      .q_pop      (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_tdata)
   );

endmodule

// ===== rtl/core/bsrch_front.sv =====
// ----------------------------------------------------------------------------
// bsrch_front
// Accepts bytes, keeps the window and byte count, and classifies each byte as
// the end of a qualifying match or not.
// ----------------------------------------------------------------------------
module bsrch_front (
   input  logic                            clock,
   input  logic                            reset,
   input  bsrch_pkg::cfg_type              cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [bsrch_pkg::BYTE_W-1:0]    in_byte,
   input  logic                            in_last,
   output logic                            push,
   output bsrch_pkg::entry_type            push_entry,
   input  logic                            queue_full
);

   logic [bsrch_pkg::BYTE_W-1:0]  window_ff [bsrch_pkg::PATTERN_MAX];
   logic [bsrch_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                          stage_valid_ff, stage_valid_in;
   logic [bsrch_pkg::COUNT_W-1:0] stage_idx_ff;
   logic                          stage_last_ff;

   logic                          accept;
   logic [bsrch_pkg::LEN_W-1:0]   len_eff;
   logic [bsrch_pkg::COUNT_W-1:0] end_pos, start_pos, anchor_pos;
   logic [bsrch_pkg::PATTERN_MAX-1:0] byte_ok;
   logic [bsrch_pkg::LEN_W-1:0]   pat_ix;
   logic                          searchable, pos_ok;

   assign push     = stage_valid_ff && !queue_full;
   assign in_ready = !stage_valid_ff || push;
   assign accept   = in_valid && in_ready;

   // Window shifts per accepted byte; count clears on last byte, saturates
   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff[0] <= in_byte;
         for (int k = 1; k < bsrch_pkg::PATTERN_MAX; k++) begin
            window_ff[k] <= window_ff[k-1];
         end
         stage_idx_ff  <= count_ff;
         stage_last_ff <= in_last;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (in_last) begin
            count_in = '0;
         end else if (count_ff <= bsrch_pkg::BLOCK_LIM) begin
            count_in = count_ff + 1'b1;
         end
      end
      stage_valid_in = accept || (stage_valid_ff && !push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Classification of the staged byte; the window already holds it in slot 0
   always_comb begin
      if (cfg.length == '0) begin
         len_eff = bsrch_pkg::LEN_W'(1);
      end else if (cfg.length > bsrch_pkg::LEN_W'(bsrch_pkg::PATTERN_MAX)) begin
         len_eff = bsrch_pkg::LEN_W'(bsrch_pkg::PATTERN_MAX);
      end else begin
         len_eff = cfg.length;
      end

      searchable = stage_idx_ff < bsrch_pkg::BLOCK_LIM;
      end_pos    = stage_idx_ff + 1'b1;
      start_pos  = end_pos - bsrch_pkg::COUNT_W'(len_eff);
      anchor_pos = bsrch_pkg::COUNT_W'(cfg.skip) + bsrch_pkg::COUNT_W'(cfg.anchor_off);

      pos_ok = searchable && (end_pos >= bsrch_pkg::COUNT_W'(len_eff))
               && (start_pos >= bsrch_pkg::COUNT_W'(cfg.skip))
               && (start_pos <= bsrch_pkg::COUNT_W'(bsrch_pkg::POS_MAX))
               && (!cfg.anchor_en || (start_pos == anchor_pos));

      // Window slot i holds the byte that must equal pattern byte len-1-i
      for (int i = 0; i < bsrch_pkg::PATTERN_MAX; i++) begin
         pat_ix     = len_eff - 1'b1 - bsrch_pkg::LEN_W'(i);
         byte_ok[i] = (bsrch_pkg::LEN_W'(i) >= len_eff)
                      || (window_ff[i] == cfg.pattern[pat_ix[bsrch_pkg::WIN_IX_W-1:0]
                                                      * bsrch_pkg::BYTE_W +: bsrch_pkg::BYTE_W]);
      end

      push_entry.hit      = pos_ok && (&byte_ok);
      push_entry.start    = start_pos[bsrch_pkg::POS_W-1:0];
      push_entry.last     = stage_last_ff;
      push_entry.too_long = stage_idx_ff >= bsrch_pkg::BLOCK_LIM;
   end

endmodule

// ===== rtl/core/bsrch_queue.sv =====
// ----------------------------------------------------------------------------
// bsrch_queue
// Short first-in first-out queue of classified bytes between the front and
// the result stage.
// ----------------------------------------------------------------------------
module bsrch_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bsrch_pkg::entry_type  push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output bsrch_pkg::entry_type  pop_entry
);

   bsrch_pkg::entry_type               slot_ff [bsrch_pkg::QUEUE_DEPTH];
   logic [bsrch_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [bsrch_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [bsrch_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full      = count_ff == bsrch_pkg::QCNT_W'(bsrch_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/bsrch_back.sv =====
// ----------------------------------------------------------------------------
// bsrch_back
// Keeps the first match of the current block and delivers the result item
// through an output register when the last byte comes out of the queue.
// ----------------------------------------------------------------------------
module bsrch_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  bsrch_pkg::entry_type               q_entry,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bsrch_pkg::RSP_DATA_W-1:0]   rsp_data
);

   logic                          match_seen_ff, match_seen_in;
   logic [bsrch_pkg::POS_W-1:0]   first_ff, first_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          out_found_ff;
   logic [bsrch_pkg::POS_W-1:0]   out_pos_ff;
   logic                          out_long_ff;
   logic                          out_free, pop_last;
   logic                          res_found;
   logic [bsrch_pkg::POS_W-1:0]   res_pos;

   assign out_free = !out_valid_ff || rsp_ready;
   assign q_pop    = q_valid && (!q_entry.last || out_free);
   assign pop_last = q_pop && q_entry.last;

   always_comb begin
      match_seen_in = match_seen_ff;
      first_in      = first_ff;
      if (q_pop && q_entry.hit && !match_seen_ff) begin
         match_seen_in = 1'b1;
         first_in      = q_entry.start;
      end
      res_found = match_seen_in;
      res_pos   = match_seen_in ? first_in : '0;
      if (pop_last) begin
         match_seen_in = 1'b0;
         first_in      = '0;
      end
      out_valid_in = pop_last || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_seen_ff <= 1'b0;
         first_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         match_seen_ff <= match_seen_in;
         first_ff      <= first_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_last) begin
         out_found_ff <= res_found;
         out_pos_ff   <= res_pos;
         out_long_ff  <= q_entry.too_long;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = bsrch_pkg::RSP_DATA_W'({out_long_ff, out_pos_ff, out_found_ff});

   // A finished block leaves no match behind for the next one.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      pop_last |=> !match_seen_ff && first_ff == '0)
      else $error("match state not cleared after last byte");

   // The first match is kept until the block ends.
   a_first_kept: assert property (@(posedge clock) disable iff (reset)
      match_seen_ff && !pop_last |=> match_seen_ff && $stable(first_ff))
      else $error("first match changed within a block");

   // No position is reported without a match.
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_found_ff |-> out_pos_ff == '0)
      else $error("position reported without a match");

endmodule

// ===== tb/sv/tb_byte_pattern_search.sv =====
// ----------------------------------------------------------------------------
// tb_byte_pattern_search
// Self-checking bench for the streaming byte pattern search block.
// ----------------------------------------------------------------------------
// Blocks of bytes are queued by the stimulus process and fed to the req_
// channel by a clocked driver. Each accepted byte is run through a local
// scanner that mirrors the search, and the scanner files one expected result
// per block. A clocked monitor takes results from the rsp_ channel and checks
// them against the oldest filed expectation. A short directed part covers the
// pattern length limits, unused pattern bytes, header skip and an anchor that
// lies beyond the block. Random phases with varied register settings follow.
// ----------------------------------------------------------------------------
module tb_byte_pattern_search;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BYTES   = 50;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 6;

   typedef struct {
      logic [bsrch_pkg::BYTE_W-1:0] data;
      logic                         is_last;
   } block_byte_type;

   typedef struct {
      logic                        found;
      logic [bsrch_pkg::POS_W-1:0] position;
      logic                        too_long;
   } search_result_type;

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bsrch_pkg::BYTE_W-1:0]     req_tdata  = '0;
   logic                             req_tlast  = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bsrch_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             csr_we     = 1'b0;
   logic [bsrch_pkg::CSR_IX_W-1:0]   csr_index  = bsrch_pkg::CSR_PATTERN_LO;
   logic [bsrch_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   // Local copy of the registers, kept in step with every write.
   logic [bsrch_pkg::HALF_W-1:0] pattern_lo  = '0;
   logic [bsrch_pkg::HALF_W-1:0] pattern_hi  = '0;
   logic [4:0]                   pattern_len = 5'd1;
   logic [bsrch_pkg::POS_W-1:0]  skip_len    = '0;
   logic                         anchor_on   = 1'b0;
   logic [bsrch_pkg::POS_W-1:0]  anchor_at   = '0;

   // Scanner state for the block in progress.
   logic [bsrch_pkg::BYTE_W-1:0] window [bsrch_pkg::PATTERN_MAX];
   int unsigned                  bytes_seen;
   bit                           match_seen;
   logic [bsrch_pkg::POS_W-1:0]  first_start;

   block_byte_type    byte_queue [$];
   search_result_type expected_results [$];

   block_byte_type    cur = '{data: '0, is_last: 1'b0};
   bit                offering;
   int                send_wait;
   bit                sender_idles   = 1'b1;
   bit                receiver_idles = 1'b1;
   int                recv_wait;
   int                long_holds;
   int                mismatches;
   int                cycle_count;
   search_result_type want;

   byte_pattern_search u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A length of zero behaves as one, and anything above the window depth is
   // clipped to the full window.
   function automatic int unsigned effective_len();
      if (pattern_len == 0) return 1;
      if (pattern_len > bsrch_pkg::PATTERN_MAX) return bsrch_pkg::PATTERN_MAX;
      return 32'(pattern_len);
   endfunction

   function automatic logic [bsrch_pkg::BYTE_W-1:0] pattern_byte(input int unsigned j);
      logic [bsrch_pkg::PAT_W-1:0] whole;
      whole = {pattern_hi, pattern_lo};
      return whole[8*j +: 8];
   endfunction

   function automatic void clear_block();
      foreach (window[k]) window[k] = '0;
      bytes_seen  = 0;
      match_seen  = 1'b0;
      first_start = '0;
   endfunction

   // Shifts one byte into the window and looks for a pattern that ends on it.
   // On the final byte of a block the expected result is filed and the block
   // state is cleared.
   function automatic void scan_byte(input logic [bsrch_pkg::BYTE_W-1:0] b,
                                     input logic is_last);
      int unsigned       idx;
      int unsigned       len;
      int unsigned       start;
      bit                hit;
      search_result_type res;
      idx = bytes_seen;
      for (int k = bsrch_pkg::PATTERN_MAX - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      // The count stops one past the countable length, which marks overflow.
      if (bytes_seen <= bsrch_pkg::BLOCK_MAX) bytes_seen++;
      if (idx < bsrch_pkg::BLOCK_MAX && !match_seen) begin
         len = effective_len();
         if (idx + 1 >= len) begin
            start = idx + 1 - len;
            hit = start >= skip_len && start <= 32'hFFFF;
            if (hit && anchor_on)
               hit = start == 32'(skip_len) + 32'(anchor_at);
            for (int i = 0; i < len; i++)
               if (window[i] != pattern_byte(len - 1 - i)) hit = 1'b0;
            if (hit) begin
               match_seen  = 1'b1;
               first_start = start[bsrch_pkg::POS_W-1:0];
            end
         end
      end
      if (is_last) begin
         res.found    = match_seen;
         res.position = match_seen ? first_start : '0;
         res.too_long = bytes_seen > bsrch_pkg::BLOCK_MAX;
         expected_results.push_back(res);
         clear_block();
      end
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < 10) $display("mismatch: %s", what);
      mismatches++;
   endtask

   task automatic queue_byte(input logic [bsrch_pkg::BYTE_W-1:0] data, input logic is_last);
      byte_queue.push_back('{data: data, is_last: is_last});
   endtask

   // Register write; the local copy takes the same masked value.
   task automatic write_csr(input logic [bsrch_pkg::CSR_IX_W-1:0] index,
                            input logic [bsrch_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         bsrch_pkg::CSR_PATTERN_LO: pattern_lo  = value;
         bsrch_pkg::CSR_PATTERN_HI: pattern_hi  = value;
         bsrch_pkg::CSR_LENGTH:     pattern_len = value[4:0];
         bsrch_pkg::CSR_SKIP:       skip_len    = value[bsrch_pkg::POS_W-1:0];
         bsrch_pkg::CSR_ANCHOR_EN:  anchor_on   = value[0];
         bsrch_pkg::CSR_ANCHOR_OFF: anchor_at   = value[bsrch_pkg::POS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Every phase ends on a final byte, so once nothing is queued, offered or
   // expected the block is idle; a settle wait then covers its pipeline.
   task automatic wait_idle();
      while (byte_queue.size() != 0 || offering || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: offers queued bytes, holding each until it is taken, with a
   // random gap drawn after every accepted item when the sender idles.
   always @(posedge clock) begin
      if (reset) begin
         offering  = 1'b0;
         send_wait = 0;
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         if (offering && req_tready) begin
            scan_byte(cur.data, cur.is_last);
            offering  = 1'b0;
            send_wait = sender_idles ? int'($urandom_range(0, 7)) : 0;
         end
         if (!offering) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (byte_queue.size() != 0) begin
               cur      = byte_queue.pop_front();
               offering = 1'b1;
            end
         end
         req_tvalid <= offering;
         req_tdata  <= cur.data;
         req_tlast  <= cur.is_last;
      end
   end

   // Monitor: checks each accepted result, then draws how long the receiver
   // stays away. At most twice, with plenty of bytes still waiting, it stays
   // away long enough for the block's queue to fill and stall the input.
   always @(posedge clock) begin
      if (reset) begin
         recv_wait = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %h with no block outstanding", rsp_tdata));
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[0] !== want.found ||
                   rsp_tdata[bsrch_pkg::POS_W:1] !== want.position ||
                   rsp_tdata[bsrch_pkg::POS_W+1] !== want.too_long)
                  report_mismatch($sformatf(
                     "found %b/%b position %0d/%0d too_long %b/%b (expected/actual)",
                     want.found, rsp_tdata[0], want.position,
                     rsp_tdata[bsrch_pkg::POS_W:1],
                     want.too_long, rsp_tdata[bsrch_pkg::POS_W+1]));
            end
            if (long_holds < 2 && byte_queue.size() > 30) begin
               recv_wait = LONG_HOLD;
               long_holds++;
            end else begin
               recv_wait = receiver_idles ? int'($urandom_range(0, 7)) : 0;
            end
         end else if (recv_wait > 0) begin
            recv_wait--;
         end
         rsp_tready <= (recv_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [bsrch_pkg::BYTE_W-1:0]     blk [32];
      logic [bsrch_pkg::CSR_DATA_W-1:0] noise;
      int unsigned                      plen;
      int                               blen;
      int                               at;
      int                               pick;
      int                               phase_bytes;
      bit                               noisy;
      clear_block();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default registers: a single zero byte, found on the final byte.
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b1);
      wait_idle();

      // A length of zero acts as one.
      write_csr(bsrch_pkg::CSR_PATTERN_LO, 64'h0000_0000_0000_00FF);
      write_csr(bsrch_pkg::CSR_LENGTH, 64'd0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      wait_idle();

      // A length above the window depth acts as the full sixteen bytes.
      write_csr(bsrch_pkg::CSR_PATTERN_LO, 64'h7766_5544_3322_1100);
      write_csr(bsrch_pkg::CSR_PATTERN_HI, 64'hFFEE_DDCC_BBAA_9988);
      write_csr(bsrch_pkg::CSR_LENGTH, 64'd20);
      for (int j = 0; j < bsrch_pkg::PATTERN_MAX; j++)
         queue_byte(8'(j * 8'h11), j == bsrch_pkg::PATTERN_MAX - 1);
      wait_idle();

      // Two-byte pattern with set bytes beyond it that must be ignored; the
      // header skip hides the match at the block start.
      write_csr(bsrch_pkg::CSR_PATTERN_LO, 64'hFFFF_FFFF_FFFF_2211);
      write_csr(bsrch_pkg::CSR_LENGTH, 64'd2);
      write_csr(bsrch_pkg::CSR_SKIP, 64'd1);
      queue_byte(8'h11, 1'b0);
      queue_byte(8'h22, 1'b0);
      queue_byte(8'h11, 1'b0);
      queue_byte(8'h22, 1'b1);
      wait_idle();

      // Anchored start far beyond the block: nothing can be found.
      write_csr(bsrch_pkg::CSR_ANCHOR_EN, 64'd1);
      write_csr(bsrch_pkg::CSR_SKIP, 64'hFFFF);
      write_csr(bsrch_pkg::CSR_ANCHOR_OFF, 64'hFFFF);
      queue_byte(8'h11, 1'b0);
      queue_byte(8'h22, 1'b1);
      wait_idle();

      // Random phases. The first uses extreme register values; the rest draw
      // their settings, with any unused upper bits of the writes randomised.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         sender_idles   = (phase % 4 != 0);
         receiver_idles = (phase % 4 != 1);
         if (phase == 0) begin
            write_csr(bsrch_pkg::CSR_PATTERN_LO, '1);
            write_csr(bsrch_pkg::CSR_PATTERN_HI, '1);
            write_csr(bsrch_pkg::CSR_LENGTH, 64'd1);
            write_csr(bsrch_pkg::CSR_SKIP, 64'd0);
            write_csr(bsrch_pkg::CSR_ANCHOR_EN, 64'd1);
            write_csr(bsrch_pkg::CSR_ANCHOR_OFF, 64'd0);
         end else begin
            write_csr(bsrch_pkg::CSR_PATTERN_LO, {$urandom, $urandom});
            write_csr(bsrch_pkg::CSR_PATTERN_HI, {$urandom, $urandom});
            pick  = int'($urandom_range(0, 9));
            noise = {$urandom, $urandom};
            noise[4:0] = pick == 0 ? 5'd0 :
                         pick == 1 ? 5'($urandom_range(16, 31)) : 5'($urandom_range(1, 6));
            write_csr(bsrch_pkg::CSR_LENGTH, noise);
            noise = {$urandom, $urandom};
            noise[bsrch_pkg::POS_W-1:0] = bsrch_pkg::POS_W'(
               $urandom_range(0, 9) < 8 ? $urandom_range(0, 4) : $urandom_range(0, 65535));
            write_csr(bsrch_pkg::CSR_SKIP, noise);
            write_csr(bsrch_pkg::CSR_ANCHOR_EN, {$urandom, $urandom});
            noise = {$urandom, $urandom};
            noise[bsrch_pkg::POS_W-1:0] = bsrch_pkg::POS_W'(
               $urandom_range(0, 9) < 8 ? $urandom_range(0, 6) : $urandom_range(0, 65535));
            write_csr(bsrch_pkg::CSR_ANCHOR_OFF, noise);
         end

         // Most blocks are built from pattern bytes, often with the
         // pattern planted, sometimes at the anchored start and sometimes
         // with one byte spoilt; the rest are plain random bytes.
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            plen  = effective_len();
            blen  = int'($urandom_range(1, plen + 8));
            noisy = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < blen; i++)
               blk[i] = noisy ? 8'($urandom) : pattern_byte($urandom_range(0, plen - 1));
            if (!noisy && blen >= plen && $urandom_range(0, 2) != 0) begin
               if (anchor_on && $urandom_range(0, 1) == 1)
                  at = int'(skip_len) + int'(anchor_at);
               else
                  at = int'($urandom_range(0, blen - plen));
               if (at + plen <= blen) begin
                  for (int i = 0; i < plen; i++) blk[at+i] = pattern_byte(i);
                  if ($urandom_range(0, 4) == 0)
                     blk[at + $urandom_range(0, plen - 1)] ^= 8'($urandom_range(1, 255));
               end
            end
            for (int i = 0; i < blen; i++) queue_byte(blk[i], i == blen - 1);
            phase_bytes += blen;
         end
         wait_idle();
      end

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/bsrch_pkg.sv
rtl/core/bsrch_front.sv
rtl/core/bsrch_queue.sv
rtl/core/bsrch_back.sv
rtl/core/byte_pattern_search.sv
tb/sv/tb_byte_pattern_search.sv
